// File: hw/rtl/hte_pkg.sv
// Package: types and constants shared by the homogeneous transform engine.
package hte_pkg;

  localparam int MAX_STEPS = 30;

  typedef enum logic [3:0] {
    FN_IDENT = 4'd0,
    FN_TRANS = 4'd1,
    FN_ROTX  = 4'd2,
    FN_ROTY  = 4'd3,
    FN_ROTZ  = 4'd4,
    FN_SCALE = 4'd5,
    FN_SMUL  = 4'd6,
    FN_NEG   = 4'd7,
    FN_POINT = 4'd8
  } func_t;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;

  // 2*pi in Q.30 as an unsigned operand, and floor(2^64 / that) for the reduction
  localparam logic [33:0] TWO_PI_U     = 34'd6746518852;
  localparam logic [31:0] TWO_PI_RECIP = 32'(65'h1_0000_0000_0000_0000 / 65'd6746518852);

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] v;
    case (i)
      5'd0: v = 36'sd843314857;
      5'd1: v = 36'sd497837829;
      5'd2: v = 36'sd263043837;
      5'd3: v = 36'sd133525159;
      5'd4: v = 36'sd67021687;
      5'd5: v = 36'sd33543516;
      5'd6: v = 36'sd16775851;
      5'd7: v = 36'sd8388437;
      5'd8: v = 36'sd4194283;
      5'd9: v = 36'sd2097149;
      default: v = 36'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v,
                                               output logic ovf);
    ovf = 1'b0;
    if (v > 80'sh7FFFFFFF) begin
      ovf = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -80'sh80000000) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: hw/rtl/hte_mac.sv
// Module: shared multiply-accumulate unit with rounding and saturation.
module hte_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] res,
  output logic               ovf
);
  logic signed [63:0] prod;
  logic signed [79:0] acc;
  logic signed [79:0] rnd;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (clr) acc <= '0;
    else if (en) acc <= acc + 80'(prod);
  end

  always_comb begin
    rnd = (acc + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    res = hte_pkg::sat32(rnd, ovf);
  end
endmodule

// File: hw/rtl/hte_div.sv
// Module: restoring divider, one quotient bit per cycle, truncating signed.
module hte_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               busy,
  output logic signed [63:0] quo
);
  logic [63:0] q;
  logic [64:0] r;
  logic [31:0] d;
  logic        neg;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {r[63:0], q[63]} - {33'd0, d};
  assign quo = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      q    <= num[63] ? 64'(-num) : num;
      r    <= '0;
      d    <= den[31] ? 32'(-den) : den;
      neg  <= num[63] ^ den[31];
    end else if (busy) begin
      if (trial[64]) begin
        r <= {r[63:0], q[63]};
        q <= {q[62:0], 1'b0};
      end else begin
        r <= trial;
        q <= {q[62:0], 1'b1};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule

// File: hw/rtl/homogeneous_transform_engine_top.sv
// Top level: homogeneous 4x4 transform engine with a sequencer over shared units.
// Usage:
// The slave channel (s_axis_*) takes one command per item: func in tdata[3:0],
// param_a, param_b and param_c above it. The master channel (m_axis_*) returns
// exactly one result item per command: out_x, out_y, out_z, w_was_zero and
// arith_fault. s_axis_tready is high only while the sequencer is idle.
// A matrix product is 16 entries times 4 multiply-accumulates on one multiplier,
// followed by write-back. Rotations first reduce the angle and run the CORDIC
// iterations, scale first divides on the divider unless its operand is zero,
// and a point takes 4 dot products plus three divisions when w is nonzero.
// Scalar multiply and negate work through the matrix entry by entry.
// Reset loads the identity matrix and empties the output register.
// A stalled receiver holds the result in the output register, and no new
// command is taken until it has been delivered.
module homogeneous_transform_engine_top #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // func[3:0], param_a, param_b, param_c
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // out_x, out_y, out_z, w_was_zero, arith_fault
);
  localparam int STEPS = (CORDIC_STEPS > hte_pkg::MAX_STEPS) ? hte_pkg::MAX_STEPS
                                                             : CORDIC_STEPS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CORD  = 9'b000000010,
    S_CFIN  = 9'b000000100,
    S_DIVW  = 9'b000001000,
    S_MAC   = 9'b000010000,
    S_WB    = 9'b000100000,
    S_PDIV  = 9'b001000000,
    S_PDW   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [3:0]  func;
  logic signed [31:0] pa, pb, pc;
  logic signed [31:0] m [16];
  logic signed [31:0] res [16];
  logic signed [31:0] rm [16];
  logic signed [31:0] tv [4];
  logic signed [31:0] sn, cs, r15;
  logic signed [35:0] cx, cy, cz;
  logic        negc;
  logic [4:0]  ci;
  logic [3:0]  ent;
  logic [2:0]  kk;
  logic [1:0]  dsel;
  logic        fault, wzero;
  logic signed [31:0] px, py, pz;

  logic               mac_clr, mac_en, mac_ovf;
  logic signed [31:0] mac_a, mac_b, mac_res;
  logic               div_start, div_start_next, div_busy;
  logic signed [63:0] div_num, div_quo;
  logic signed [31:0] div_den;
  logic signed [31:0] qsat, csat, ssat;
  logic               qovf, covf, sovf;
  logic signed [35:0] cxr, zred, zr;
  logic [31:0]        amag;
  logic [63:0]        rprod;
  logic [21:0]        qest;
  logic [55:0]        rem, remc;
  logic signed [35:0] cxo, cyo;
  logic signed [31:0] negv;
  logic               negovf;

  hte_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b),
    .res(mac_res), .ovf(mac_ovf)
  );

  hte_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  // right-hand matrix for post-multiply
  always_comb begin
    for (int k = 0; k < 16; k++) rm[k] = (k % 5 == 0) ? ONE : 32'sd0;
    case (func)
      hte_pkg::FN_TRANS: begin
        rm[3] = pa; rm[7] = pb; rm[11] = pc;
      end
      hte_pkg::FN_ROTX: begin
        rm[5] = cs; rm[10] = cs; rm[9] = sn; rm[6] = -sn;
      end
      hte_pkg::FN_ROTY: begin
        rm[0] = cs; rm[10] = cs; rm[8] = -sn; rm[2] = sn;
      end
      hte_pkg::FN_ROTZ: begin
        rm[0] = cs; rm[5] = cs; rm[4] = sn; rm[1] = -sn;
      end
      hte_pkg::FN_SCALE: rm[15] = r15;
      default: ;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mac_a = 32'sd0;
    mac_b = 32'sd0;
    case (func)
      hte_pkg::FN_SMUL: begin
        mac_a = (kk == 3'd0) ? m[ent] : 32'sd0;
        mac_b = pa;
      end
      hte_pkg::FN_POINT: begin
        mac_a = (kk < 3'd4) ? m[{ent[1:0], kk[1:0]}] : 32'sd0;
        case (kk[1:0])
          2'd0: mac_b = pa;
          2'd1: mac_b = pb;
          2'd2: mac_b = pc;
          default: mac_b = ONE;
        endcase
      end
      default: begin
        mac_a = (kk < 3'd4) ? m[{ent[3:2], kk[1:0]}] : 32'sd0;
        mac_b = rm[{kk[1:0], ent[1:0]}];
      end
    endcase
  end

  // products pass through the prod register before they reach acc; kk 1..4 accumulate
  assign mac_en  = (state == S_MAC) && (kk != 3'd0) && (kk <= 3'd4);
  assign mac_clr = (state != S_MAC) || (kk == 3'd0);

  always_comb begin
    qsat = hte_pkg::sat32(80'(div_quo), qovf);
    // angle reduction mod 2*pi by reciprocal multiply, one correction step
    amag = pa[31] ? 32'(-pa) : pa;
    qest = 22'(rprod >> (34 + FRAC_BITS));
    remc = (rem >= 56'(hte_pkg::TWO_PI_U)) ? rem - 56'(hte_pkg::TWO_PI_U) : rem;
    zred = pa[31] ? -36'(remc) : 36'(remc);
    zr   = zred;
    if (zred > hte_pkg::Q30_PI) zr = zred - hte_pkg::Q30_TWO_PI;
    else if (zred < -hte_pkg::Q30_PI) zr = zred + hte_pkg::Q30_TWO_PI;
    cxr  = negc ? -cx : cx;
    cxo  = (cxr + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    cyo  = (cy + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    csat = hte_pkg::sat32(80'(cxo), covf);
    ssat = hte_pkg::sat32(80'(cyo), sovf);
    negv = hte_pkg::sat32(-80'(m[ent]), negovf);
    case (dsel)
      2'd0: div_num = 64'(tv[0]) <<< FRAC_BITS;
      2'd1: div_num = 64'(tv[1]) <<< FRAC_BITS;
      default: div_num = 64'(tv[2]) <<< FRAC_BITS;
    endcase
    if (func == hte_pkg::FN_SCALE) begin
      div_num = 64'sd1 <<< (2 * FRAC_BITS);
      div_den = pa;
    end else begin
      div_den = tv[3];
    end
  end

  always_comb begin
    div_start_next = 1'b0;
    case (state)
      S_IDLE: div_start_next = s_axis_tvalid && s_axis_tready &&
                               (s_axis_tdata[3:0] == hte_pkg::FN_SCALE) &&
                               (s_axis_tdata[35:4] != 32'd0);
      S_PDIV: div_start_next = (tv[3] != 32'sd0);
      S_PDW:  div_start_next = !div_start && !div_busy && (dsel != 2'd2);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) div_start <= 1'b0;
    else div_start <= div_start_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < 16; k++) m[k] <= (k % 5 == 0) ? ONE : 32'sd0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          func  <= s_axis_tdata[3:0];
          pa    <= s_axis_tdata[35:4];
          pb    <= s_axis_tdata[67:36];
          pc    <= s_axis_tdata[99:68];
          fault <= (s_axis_tdata[3:0] == hte_pkg::FN_SCALE) &&
                   (s_axis_tdata[35:4] == 32'd0);
          wzero <= 1'b0;
          px <= '0; py <= '0; pz <= '0;
          ent <= '0; kk <= '0; ci <= '0;
          case (s_axis_tdata[3:0])
            hte_pkg::FN_IDENT: begin
              for (int k = 0; k < 16; k++) m[k] <= (k % 5 == 0) ? ONE : 32'sd0;
              state <= S_OUT;
            end
            hte_pkg::FN_TRANS, hte_pkg::FN_SMUL, hte_pkg::FN_POINT: state <= S_MAC;
            hte_pkg::FN_ROTX, hte_pkg::FN_ROTY, hte_pkg::FN_ROTZ: state <= S_CFIN;
            hte_pkg::FN_SCALE: begin
              if (s_axis_tdata[35:4] == 32'd0) begin
                r15 <= 32'sh7FFFFFFF;
                state <= S_MAC;
              end else begin
                state <= S_DIVW;
              end
            end
            hte_pkg::FN_NEG: state <= S_WB;
            default: state <= S_OUT;
          endcase
        end
        S_CFIN: begin
          // angle reduction: reciprocal multiply, then remainder, then fold
          if (ci == 5'd0) begin
            rprod <= amag * hte_pkg::TWO_PI_RECIP;
            ci <= ci + 5'd1;
          end else if (ci == 5'd1) begin
            rem <= (56'(amag) << (30 - FRAC_BITS)) - qest * hte_pkg::TWO_PI_U;
            ci <= ci + 5'd1;
          end else begin
            cx <= hte_pkg::Q30_GAIN;
            cy <= '0;
            ci <= '0;
            if (zr > hte_pkg::Q30_HALF_PI) begin
              cz <= hte_pkg::Q30_PI - zr; negc <= 1'b1;
            end else if (zr < -hte_pkg::Q30_HALF_PI) begin
              cz <= -hte_pkg::Q30_PI - zr; negc <= 1'b1;
            end else begin
              cz <= zr; negc <= 1'b0;
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (ci == 5'(STEPS)) begin
            cs <= csat; sn <= ssat;
            if (covf || sovf) fault <= 1'b1;
            state <= S_MAC;
          end else begin
            if (!cz[35]) begin
              cx <= cx - (cy >>> ci); cy <= cy + (cx >>> ci);
              cz <= cz - hte_pkg::atan_q30(ci);
            end else begin
              cx <= cx + (cy >>> ci); cy <= cy - (cx >>> ci);
              cz <= cz + hte_pkg::atan_q30(ci);
            end
            ci <= ci + 5'd1;
          end
        end
        S_DIVW: if (!div_start && !div_busy) begin
          r15 <= qsat;
          if (qovf) fault <= 1'b1;
          state <= S_MAC;
        end
        S_MAC: begin
          if (kk == 3'd5) begin
            kk <= '0;
            if (mac_ovf) fault <= 1'b1;
            if (func == hte_pkg::FN_POINT) begin
              tv[ent[1:0]] <= mac_res;
              if (ent == 4'd3) begin
                ent <= '0;
                state <= S_PDIV;
              end else ent <= ent + 4'd1;
            end else begin
              if (func == hte_pkg::FN_SMUL) m[ent] <= mac_res;
              else res[ent] <= mac_res;
              if (ent == 4'd15) begin
                ent <= '0;
                state <= (func == hte_pkg::FN_SMUL) ? S_OUT : S_WB;
              end else ent <= ent + 4'd1;
            end
          end else kk <= kk + 3'd1;
        end
        S_WB: begin
          if (func == hte_pkg::FN_NEG) begin
            m[ent] <= negv;
            if (negovf) fault <= 1'b1;
            ent <= ent + 4'd1;
            if (ent == 4'd15) state <= S_OUT;
          end else begin
            for (int k = 0; k < 16; k++) m[k] <= res[k];
            state <= S_OUT;
          end
        end
        S_PDIV: begin
          if (tv[3] == 32'sd0) begin
            wzero <= 1'b1;
            px <= tv[0]; py <= tv[1]; pz <= tv[2];
            state <= S_OUT;
          end else begin
            dsel <= 2'd0;
            state <= S_PDW;
          end
        end
        S_PDW: if (!div_start && !div_busy) begin
          if (qovf) fault <= 1'b1;
          case (dsel)
            2'd0: px <= qsat;
            2'd1: py <= qsat;
            default: pz <= qsat;
          endcase
          if (dsel == 2'd2) state <= S_OUT;
          else dsel <= dsel + 2'd1;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {6'd0, fault, wzero, pz, py, px};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/hte_checker.sv
// Checker: port-level properties of the transform engine, bound to the top level.
module hte_sva (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[103:98] == 6'd0)
    else $error("padding bits set");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result after reset");
endmodule

bind homogeneous_transform_engine_top hte_sva u_hte_sva (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

// File: tb/hte_checker.sv
// Checker: predicts the transform engine's results and compares the output items.
module hte_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  output int           fails,
  output int           pending
);

  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;

  typedef logic signed [31:0] q_t;
  typedef q_t vec4_t [4];

  typedef struct packed {
    q_t   px;
    q_t   py;
    q_t   pz;
    logic wzero;
    logic fault;
  } point_res_t;

  q_t         xform [16];
  point_res_t expected_q [$];

  function automatic q_t clamp32(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return S_MAX;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return 32'sh80000000;
    end
    return q_t'(v);
  endfunction

  function automatic q_t round_dot(vec4_t a, vec4_t b, inout bit f);
    longint hi, lo, p, h;
    hi = 0;
    lo = 0;
    for (int k = 0; k < 4; k++) begin
      p = longint'(a[k]) * longint'(b[k]);
      h = p >>> FRAC;
      hi += h;
      lo += p - h * (64'sd1 <<< FRAC);
    end
    lo += 64'sd1 <<< (FRAC - 1);
    return clamp32(hi + (lo >>> FRAC), f);
  endfunction

  function automatic void unit_matrix(output q_t m [16]);
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? Q_ONE : 32'sd0;
  endfunction

  function automatic void mul_right(q_t r [16], inout bit f);
    q_t    res [16];
    vec4_t rowv, colv;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          rowv[k] = xform[i*4+k];
          colv[k] = r[k*4+j];
        end
        res[i*4+j] = round_dot(rowv, colv, f);
      end
    end
    xform = res;
  endfunction

  function automatic void sincos(q_t ang, output q_t sn, output q_t cs, inout bit f);
    longint z, x, y, dx, dy, pi, hpi, tpi;
    bit     flip;
    pi = longint'(hte_pkg::Q30_PI);
    hpi = longint'(hte_pkg::Q30_HALF_PI);
    tpi = longint'(hte_pkg::Q30_TWO_PI);
    z = (longint'(ang) * (64'sd1 <<< (30 - FRAC))) % tpi;
    x = longint'(hte_pkg::Q30_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > pi) z -= tpi;
    else if (z < -pi) z += tpi;
    if (z > hpi) begin
      z = pi - z;
      flip = 1'b1;
    end else if (z < -hpi) begin
      z = -pi - z;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(hte_pkg::atan_q30(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(hte_pkg::atan_q30(5'(i)));
      end
    end
    if (flip) x = -x;
    cs = clamp32((x + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC), f);
    sn = clamp32((y + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC), f);
  endfunction

  function automatic point_res_t run_command(logic [3:0] fn, q_t a, q_t b, q_t c);
    point_res_t res;
    q_t         r [16];
    q_t         sn, cs;
    vec4_t      ta, tb4, v, t;
    bit         f;
    longint     one;
    f = 1'b0;
    res = '0;
    one = 64'sd1 <<< FRAC;
    unit_matrix(r);
    case (fn)
      hte_pkg::FN_IDENT: unit_matrix(xform);
      hte_pkg::FN_TRANS: begin
        r[3] = a; r[7] = b; r[11] = c;
        mul_right(r, f);
      end
      hte_pkg::FN_ROTX: begin
        sincos(a, sn, cs, f);
        r[5] = cs; r[10] = cs; r[9] = sn; r[6] = -sn;
        mul_right(r, f);
      end
      hte_pkg::FN_ROTY: begin
        sincos(a, sn, cs, f);
        r[0] = cs; r[10] = cs; r[8] = -sn; r[2] = sn;
        mul_right(r, f);
      end
      hte_pkg::FN_ROTZ: begin
        sincos(a, sn, cs, f);
        r[0] = cs; r[5] = cs; r[4] = sn; r[1] = -sn;
        mul_right(r, f);
      end
      hte_pkg::FN_SCALE: begin
        if (a == 0) begin
          f = 1'b1;
          r[15] = S_MAX;
        end else begin
          r[15] = clamp32((64'sd1 <<< (2 * FRAC)) / longint'(a), f);
        end
        mul_right(r, f);
      end
      hte_pkg::FN_SMUL: begin
        for (int k = 0; k < 16; k++) begin
          ta = '{xform[k], 0, 0, 0};
          tb4 = '{a, 0, 0, 0};
          xform[k] = round_dot(ta, tb4, f);
        end
      end
      hte_pkg::FN_NEG: begin
        for (int k = 0; k < 16; k++) xform[k] = clamp32(-longint'(xform[k]), f);
      end
      hte_pkg::FN_POINT: begin
        v = '{a, b, c, Q_ONE};
        for (int k = 0; k < 4; k++) begin
          ta = '{xform[k*4], xform[k*4+1], xform[k*4+2], xform[k*4+3]};
          t[k] = round_dot(ta, v, f);
        end
        if (t[3] != 0) begin
          res.px = clamp32(longint'(t[0]) * one / longint'(t[3]), f);
          res.py = clamp32(longint'(t[1]) * one / longint'(t[3]), f);
          res.pz = clamp32(longint'(t[2]) * one / longint'(t[3]), f);
        end else begin
          res.wzero = 1'b1;
          res.px = t[0]; res.py = t[1]; res.pz = t[2];
        end
      end
      default: ;
    endcase
    res.fault = f;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    point_res_t e;
    if (rst) begin
      unit_matrix(xform);
      expected_q.delete();
      fails = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(run_command(s_axis_tdata[3:0], s_axis_tdata[35:4],
                                         s_axis_tdata[67:36], s_axis_tdata[99:68]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[31:0], 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata[31:0] !== e.px) report_mismatch("out_x", m_axis_tdata[31:0], e.px);
          if (m_axis_tdata[63:32] !== e.py) report_mismatch("out_y", m_axis_tdata[63:32], e.py);
          if (m_axis_tdata[95:64] !== e.pz) report_mismatch("out_z", m_axis_tdata[95:64], e.pz);
          if (m_axis_tdata[96] !== e.wzero)
            report_mismatch("w_was_zero", 32'(m_axis_tdata[96]), 32'(e.wzero));
          if (m_axis_tdata[97] !== e.fault)
            report_mismatch("arith_fault", 32'(m_axis_tdata[97]), 32'(e.fault));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top: drives commands into the transform engine and gives the verdict.
module tb;

  localparam logic signed [31:0] Q_ONE = 32'sh00010000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_PI  = 32'sd205887;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  int           fails;
  int           pending;
  int           snd_pct;
  int           rcv_pct;
  logic         hold_tog;
  logic         hold_seen;
  int           hold_cnt;

  homogeneous_transform_engine_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  hte_checker u_chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_seen = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_tog !== hold_seen) begin
        hold_seen = hold_tog;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_pct);
      end
    end
  end

  task automatic send_cmd(logic [3:0] fn, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < snd_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, c, b, a, fn};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [31:0] rand_param();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 32'($signed($urandom_range(0, 524288)) - 262144);
    if (sel < 80) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return S_MAX;
      2: return S_MIN;
      3: return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  task automatic run_phase(int n_items, bit do_hold);
    int sent;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_cmd(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom);
        sent++;
      end else begin
        send_cmd(hte_pkg::FN_IDENT, rand_param(), rand_param(), rand_param());
        sent++;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
          send_cmd(4'($urandom_range(hte_pkg::FN_TRANS, hte_pkg::FN_NEG)), rand_param(),
                   rand_param(), rand_param());
        sent += n;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
          send_cmd(hte_pkg::FN_POINT, rand_param(), rand_param(), rand_param());
        sent += n;
      end
      if (do_hold && sent > 40) begin
        do_hold = 1'b0;
        hold_tog <= ~hold_tog;
      end
    end
  endtask

  initial begin
    int wait_cnt;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_tog = 1'b0;
    snd_pct = 0;
    rcv_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_cmd(hte_pkg::FN_TRANS, S_MAX, S_MIN, 32'd0);
    send_cmd(hte_pkg::FN_POINT, S_MAX, S_MIN, Q_ONE);
    send_cmd(hte_pkg::FN_IDENT, S_MIN, S_MAX, S_MAX);
    send_cmd(hte_pkg::FN_ROTX, 32'd0, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_ROTY, Q_PI, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_ROTZ, -Q_PI, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_ROTX, S_MAX, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_ROTY, S_MIN, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_ROTZ, 32'sd102944, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_POINT, Q_ONE, -Q_ONE, 32'sd131072);
    send_cmd(hte_pkg::FN_SCALE, 32'd0, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_SCALE, 32'd1, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_SCALE, S_MIN, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_POINT, S_MAX, S_MAX, S_MAX);
    send_cmd(hte_pkg::FN_IDENT, 32'd0, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_SMUL, S_MAX, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_SMUL, S_MIN, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_NEG, 32'd0, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_POINT, 32'sd7, S_MIN, -32'sd3);
    send_cmd(hte_pkg::FN_SMUL, 32'd0, 32'd0, 32'd0);
    send_cmd(hte_pkg::FN_POINT, Q_ONE, Q_ONE, Q_ONE);
    send_cmd(4'd9, S_MAX, S_MAX, S_MAX);
    send_cmd(4'd15, S_MIN, S_MIN, S_MIN);
    send_cmd(hte_pkg::FN_IDENT, 32'd0, 32'd0, 32'd0);

    // random, by idle phase
    run_phase(300, 1'b0);
    snd_pct = 69;
    run_phase(280, 1'b0);
    snd_pct = 0;
    rcv_pct = 69;
    run_phase(280, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    snd_pct = 8;
    rcv_pct = 8;
    run_phase(280, 1'b0);
    snd_pct = 0;
    rcv_pct = 0;
    run_phase(280, 1'b0);

    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (300) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hte_pkg.sv
hw/rtl/hte_mac.sv
hw/rtl/hte_div.sv
hw/rtl/homogeneous_transform_engine_top.sv
hw/rtl/hte_checker.sv
tb/hte_checker.sv
tb/tb.sv
